@@ src/psrl_pkg.sv @@
// ----------------------------------------------------------------------------
// Per-source rate limiter package
// Shared word types, table entry layout, register indexes and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package psrl_pkg;

    // Table size default and fixed field widths.
    localparam int MAX_SOURCES_DEF = 64;
    localparam int TIME_W          = 48;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;

    // Configuration reset values.
    localparam logic [31:0] WINDOW_MS_RESET = 32'd1000;
    localparam logic [15:0] THRESHOLD_RESET = 16'd100;

    // Trusted-packet recognition and counter limit.
    localparam logic [31:0] TRUST_MAGIC   = 32'hAABB_CCDD;
    localparam logic [7:0]  TRUST_VERSION = 8'd1;
    localparam logic [7:0]  CHANNEL_MIN   = 8'd1;
    localparam logic [7:0]  CHANNEL_MAX   = 8'd6;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    // Input word.
    typedef struct packed {
        logic              has_source;
        logic [63:0]       addr_hi;
        logic [63:0]       addr_lo;
        logic [15:0]       l4_port;
        logic [TIME_W-1:0] now_ms;
        logic [31:0]       session;
        logic [7:0]        channel;
        logic [31:0]       header_magic;
        logic [7:0]        header_version;
    } t_in_word;

    // Output word.
    typedef struct packed {
        logic drop;
        logic new_entry;
        logic evicted;
    } t_out_word;

    // Configuration held by the top level.
    typedef struct packed {
        logic [31:0] window_ms;
        logic [15:0] threshold;
    } t_cfg;

    // One entry of the source table.
    typedef struct packed {
        logic [63:0]       key_high;
        logic [63:0]       key_low;
        logic [15:0]       key_port;
        logic [TIME_W-1:0] window_start;
        logic [15:0]       packet_count;
    } t_entry;

endpackage : psrl_pkg

`default_nettype wire

@@ src/psrl_mem.sv @@
// ----------------------------------------------------------------------------
// Source table memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module psrl_mem #(
    parameter int DEPTH = psrl_pkg::MAX_SOURCES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                  i_clk,
    input  wire                  i_wr_en,
    input  wire [AW-1:0]         i_wr_addr,
    input  psrl_pkg::t_entry     i_wr_data,
    input  wire                  i_rd_en,
    input  wire [AW-1:0]         i_rd_addr,
    output psrl_pkg::t_entry     o_rd_data
);
    import psrl_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule : psrl_mem

`default_nettype wire

@@ src/psrl_engine.sv @@
// ----------------------------------------------------------------------------
// Rate limiter engine
// Searches the source table, evicts and creates entries, and applies the
// fixed-window count to one word at a time, leaving trusted words uncounted.
// ----------------------------------------------------------------------------
`default_nettype none

module psrl_engine #(
    parameter int MAX_SOURCES = psrl_pkg::MAX_SOURCES_DEF,
    parameter int IDX_W       = $clog2(MAX_SOURCES),
    parameter int CNT_W       = $clog2(MAX_SOURCES + 1)
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  psrl_pkg::t_cfg       i_cfg,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  psrl_pkg::t_in_word   i_in_word,
    output logic                 o_res_valid,
    input  wire                  i_res_ready,
    output psrl_pkg::t_out_word  o_res_word,
    output logic [CNT_W-1:0]     o_used,
    output logic                 o_mem_wr_en,
    output logic [IDX_W-1:0]     o_mem_wr_addr,
    output psrl_pkg::t_entry     o_mem_wr_data,
    output logic                 o_mem_rd_en,
    output logic [IDX_W-1:0]     o_mem_rd_addr,
    input  psrl_pkg::t_entry     i_mem_rd_data
);
    import psrl_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SOURCES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_SOURCES);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_SEARCH  = 8'b0000_0010,
        S_CALC    = 8'b0000_0100,
        S_UPDATE  = 8'b0000_1000,
        S_COPY_RD = 8'b0001_0000,
        S_COPY_WR = 8'b0010_0000,
        S_CREATE  = 8'b0100_0000,
        S_RESULT  = 8'b1000_0000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    t_in_word            r_item;
    logic                r_trusted;
    logic                r_evict;
    logic [CNT_W-1:0]    r_used;
    logic [CNT_W-1:0]    r_rd_idx;
    logic                r_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic [TIME_W-1:0]   r_min_ws;
    logic [IDX_W-1:0]    r_min_idx;
    logic [IDX_W-1:0]    r_hit_idx;
    t_entry              r_entry;
    logic                r_expired;
    t_out_word           r_res;

    logic                w_trusted_in;
    logic                w_issue;
    logic                w_hit;
    logic                w_new_min;
    logic [TIME_W-1:0]   w_elapsed;
    logic [15:0]         w_cnt_base;
    logic [15:0]         w_cnt_next;
    logic [TIME_W-1:0]   w_ws_next;

    // Trusted packets are recognised as they are accepted.
    assign w_trusted_in = (i_in_word.session != '0) &&
                          (i_in_word.channel >= CHANNEL_MIN) &&
                          (i_in_word.channel <= CHANNEL_MAX) &&
                          (i_in_word.header_magic == TRUST_MAGIC) &&
                          (i_in_word.header_version == TRUST_VERSION);

    // Search pipeline: one read issued and one entry compared per cycle.
    assign w_issue   = (r_state == S_SEARCH) && (r_rd_idx < r_used);
    assign w_hit     = r_cmp_vld &&
                       (i_mem_rd_data.key_high == r_item.addr_hi) &&
                       (i_mem_rd_data.key_low  == r_item.addr_lo) &&
                       (i_mem_rd_data.key_port == r_item.l4_port);
    assign w_new_min = (r_cmp_idx == '0) || (i_mem_rd_data.window_start < r_min_ws);

    // Window arithmetic for a matching entry.
    assign w_elapsed  = r_item.now_ms - r_entry.window_start;
    assign w_cnt_base = r_expired ? 16'd0 : r_entry.packet_count;
    assign w_cnt_next = (w_cnt_base == COUNT_MAX) ? w_cnt_base : w_cnt_base + 16'd1;
    assign w_ws_next  = r_expired ? r_item.now_ms : r_entry.window_start;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_in_word.has_source ? S_SEARCH : S_RESULT;
                end
            end
            S_SEARCH: begin
                if (w_hit) begin
                    n_state = S_CALC;
                end else if (!w_issue) begin
                    n_state = (r_used == FULL_CNT) ? S_COPY_RD : S_CREATE;
                end
            end
            S_CALC:    n_state = S_UPDATE;
            S_UPDATE:  n_state = S_RESULT;
            S_COPY_RD: n_state = S_COPY_WR;
            S_COPY_WR: n_state = S_CREATE;
            S_CREATE:  n_state = S_RESULT;
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Memory port control.
    always_comb begin
        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = r_rd_idx[IDX_W-1:0];
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_hit_idx;
        o_mem_wr_data = r_entry;
        case (r_state)
            S_SEARCH: begin
                o_mem_rd_en = w_issue;
            end
            S_UPDATE: begin
                o_mem_wr_en                = !r_trusted;
                o_mem_wr_data.window_start = w_ws_next;
                o_mem_wr_data.packet_count = w_cnt_next;
            end
            S_COPY_RD: begin
                o_mem_rd_en   = 1'b1;
                o_mem_rd_addr = LAST_IDX;
            end
            S_COPY_WR: begin
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = r_min_idx;
                o_mem_wr_data = i_mem_rd_data;
            end
            S_CREATE: begin
                o_mem_wr_en                = 1'b1;
                o_mem_wr_addr              = r_used[IDX_W-1:0];
                o_mem_wr_data.key_high     = r_item.addr_hi;
                o_mem_wr_data.key_low      = r_item.addr_lo;
                o_mem_wr_data.key_port     = r_item.l4_port;
                o_mem_wr_data.window_start = r_item.now_ms;
                o_mem_wr_data.packet_count = r_trusted ? 16'd0 : 16'd1;
            end
            default: begin
                o_mem_rd_en = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= w_issue;
            if (r_state == S_COPY_WR) begin
                r_used <= r_used - CNT_W'(1);
            end else if (r_state == S_CREATE) begin
                r_used <= r_used + CNT_W'(1);
            end
        end
    end

    // Working registers for the word in flight.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_item    <= i_in_word;
                    r_trusted <= w_trusted_in;
                    r_evict   <= 1'b0;
                    r_rd_idx  <= '0;
                    r_res     <= '0;
                end
            end
            S_SEARCH: begin
                if (w_issue) begin
                    r_rd_idx <= r_rd_idx + CNT_W'(1);
                end
                r_cmp_idx <= r_rd_idx[IDX_W-1:0];
                if (w_hit) begin
                    r_hit_idx <= r_cmp_idx;
                    r_entry   <= i_mem_rd_data;
                end else if (r_cmp_vld && w_new_min) begin
                    r_min_ws  <= i_mem_rd_data.window_start;
                    r_min_idx <= r_cmp_idx;
                end
            end
            S_CALC: begin
                r_expired <= w_elapsed > {{(TIME_W-32){1'b0}}, i_cfg.window_ms};
            end
            S_UPDATE: begin
                r_res.drop <= !r_trusted && (w_cnt_next > i_cfg.threshold);
            end
            S_COPY_WR: begin
                r_evict <= 1'b1;
            end
            S_CREATE: begin
                r_res.drop      <= !r_trusted && (i_cfg.threshold == 16'd0);
                r_res.new_entry <= 1'b1;
                r_res.evicted   <= r_evict;
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);
    assign o_res_word  = r_res;
    assign o_used      = r_used;

endmodule : psrl_engine

`default_nettype wire

@@ src/per_source_rate_limiter_unit.sv @@
// Flow: one word at a time; a new word is taken only once the result of the last
//   has gone to the output register, and a word with a source searches the table
//   linearly through the single read port of the source table.
// Reset: clears the fill count, the control state and the output valid flag, and
//   loads window_ms 1000 and threshold 100; table contents are not cleared.
// ----------------------------------------------------------------------------
// Per-source rate limiter
// Fixed-window packet rate limiter with one window per source address and
// port, kept in a table with oldest-window eviction.
// ----------------------------------------------------------------------------
`default_nettype none

module per_source_rate_limiter_unit #(
    parameter int MAX_SOURCES = psrl_pkg::MAX_SOURCES_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire [psrl_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [psrl_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  psrl_pkg::t_in_word                   i_in_word,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output psrl_pkg::t_out_word                  o_out_word
);
    import psrl_pkg::*;

    localparam int IDX_W = $clog2(MAX_SOURCES);
    localparam int CNT_W = $clog2(MAX_SOURCES + 1);

    t_cfg              r_cfg;
    logic              r_out_valid;
    t_out_word         r_out_word;

    logic              w_res_valid;
    logic              w_res_ready;
    t_out_word         w_res_word;
    logic [CNT_W-1:0]  w_used;
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_addr;
    t_entry            w_wr_data;
    logic              w_rd_en;
    logic [IDX_W-1:0]  w_rd_addr;
    t_entry            w_rd_data;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ms <= WINDOW_MS_RESET;
            r_cfg.threshold <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW_MS: r_cfg.window_ms <= i_cfg_data;
                REG_THRESHOLD: r_cfg.threshold <= i_cfg_data[15:0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    // Engine: search, eviction, creation and window count.
    psrl_engine #(
        .MAX_SOURCES (MAX_SOURCES),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_word     (i_in_word),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (w_res_ready),
        .o_res_word    (w_res_word),
        .o_used        (w_used),
        .o_mem_wr_en   (w_wr_en),
        .o_mem_wr_addr (w_wr_addr),
        .o_mem_wr_data (w_wr_data),
        .o_mem_rd_en   (w_rd_en),
        .o_mem_rd_addr (w_rd_addr),
        .i_mem_rd_data (w_rd_data)
    );

    // Source table.
    psrl_mem #(
        .DEPTH (MAX_SOURCES),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Output register; the engine hands over a word whenever it is free or its word is taken.
    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out_word <= w_res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // A word without a source yields an all-zero result in the next cycle.
    a_no_source_pass : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_in_word.has_source) |=>
            (w_res_valid && (w_res_word == '0)))
        else $error("word without a source did not pass straight through");

    // Only one word is in flight: no acceptance while a result is pending.
    a_one_in_flight : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> !o_in_ready)
        else $error("input accepted while a result is pending");

    // The fill count never exceeds the table size.
    a_used_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used <= CNT_W'(MAX_SOURCES))
        else $error("table fill count beyond table size");

    // An eviction only happens on a full table and always creates an entry.
    a_evict_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res_word.evicted) |->
            (w_res_word.new_entry && (w_used == CNT_W'(MAX_SOURCES))))
        else $error("eviction reported without a full table");

endmodule : per_source_rate_limiter_unit

`default_nettype wire

@@ bench/per_source_rate_limiter_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Per-source rate limiter testbench
// Feeds packet words through the valid/ready input channel and predicts every
// verdict with a behavioural copy of the source table and its fixed-window
// counters. Each verdict is compared flag by flag with the oldest prediction.
// Covers missing sources, trusted packets and near misses, window expiry across
// the time wrap, counting past the threshold, full-table eviction and register
// changes.
// ----------------------------------------------------------------------------

module per_source_rate_limiter_unit_tb;

    import psrl_pkg::*;

    localparam int TABLE_DEPTH  = MAX_SOURCES_DEF;
    localparam int POOL_SIZE    = 96;
    localparam int HOT_SOURCES  = 8;
    localparam int PHASE_WORDS  = 325;
    localparam int SETTLE_TICKS = 4;

    // Register indexes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // A source key: address pair and port.
    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [15:0] port;
    } t_source;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_word  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_word;

    // Predicted state of the block.
    t_entry      source_table [TABLE_DEPTH];
    int          sources_held   = 0;
    logic [31:0] held_window_ms = WINDOW_MS_RESET;
    logic [15:0] held_threshold = THRESHOLD_RESET;

    t_in_word          packets_waiting[$];
    t_out_word         verdicts_due[$];
    t_source           source_pool [POOL_SIZE];
    logic [TIME_W-1:0] packet_clock = '0;
    bit                idling_on    = 1'b0;
    int                send_hold    = 0;
    int                take_hold    = 0;
    int                mismatches   = 0;

    per_source_rate_limiter_unit #(
        .MAX_SOURCES (TABLE_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Looks the source up, evicts and creates as needed, then applies the
    // fixed-window count unless the packet is trusted.
    function automatic t_out_word rate_verdict(t_in_word w);
        t_out_word         v;
        int                i;
        int                slot;
        int                oldest;
        bit                hit;
        bit                trusted;
        logic [TIME_W-1:0] elapsed;
        v = '0;
        if (!w.has_source) begin
            return v;
        end
        slot = 0;
        hit  = 1'b0;
        for (i = 0; i < sources_held && !hit; i++) begin
            if (source_table[i].key_high == w.addr_hi && source_table[i].key_low == w.addr_lo &&
                source_table[i].key_port == w.l4_port) begin
                slot = i;
                hit  = 1'b1;
            end
        end
        if (!hit) begin
            // A full table gives up the entry whose window began first; the
            // last entry moves into its place.
            if (sources_held >= TABLE_DEPTH) begin
                oldest = 0;
                for (i = 1; i < sources_held; i++) begin
                    if (source_table[i].window_start < source_table[oldest].window_start) begin
                        oldest = i;
                    end
                end
                source_table[oldest] = source_table[sources_held - 1];
                sources_held--;
                v.evicted = 1'b1;
            end
            slot = sources_held;
            sources_held++;
            source_table[slot] = '{key_high: w.addr_hi, key_low: w.addr_lo,
                                   key_port: w.l4_port, window_start: w.now_ms,
                                   packet_count: 16'd0};
            v.new_entry = 1'b1;
        end
        trusted = w.session != 32'd0 && w.channel >= CHANNEL_MIN && w.channel <= CHANNEL_MAX &&
                  w.header_magic == TRUST_MAGIC && w.header_version == TRUST_VERSION;
        if (!trusted) begin
            elapsed = w.now_ms - source_table[slot].window_start;
            if (elapsed > {16'd0, held_window_ms}) begin
                source_table[slot].packet_count = 16'd0;
                source_table[slot].window_start = w.now_ms;
            end
            if (source_table[slot].packet_count < COUNT_MAX) begin
                source_table[slot].packet_count++;
            end
            v.drop = source_table[slot].packet_count > held_threshold;
        end
        return v;
    endfunction

    function automatic t_in_word packet_of(logic has, t_source s, logic [TIME_W-1:0] now,
                                           logic [31:0] sess, logic [7:0] chan,
                                           logic [31:0] magic, logic [7:0] ver);
        t_in_word p;
        p = '{has_source: has, addr_hi: s.hi, addr_lo: s.lo, l4_port: s.port, now_ms: now,
              session: sess, channel: chan, header_magic: magic, header_version: ver};
        return p;
    endfunction

    // Random traffic: mostly a few busy sources, a wider pool that overfills
    // the table, and the odd one-off source. Time mostly creeps forward.
    function automatic t_in_word random_packet(int max_step);
        t_in_word p;
        t_source  s;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            s = source_pool[$urandom_range(0, HOT_SOURCES - 1)];
        end else if (pick < 90) begin
            s = source_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
            s.hi   = {$urandom, $urandom};
            s.lo   = {$urandom, $urandom};
            s.port = 16'($urandom);
        end
        case ($urandom_range(0, 9))
            0, 1, 2: begin
            end
            9: begin
                packet_clock = {16'($urandom), $urandom};
            end
            default: begin
                packet_clock = packet_clock + $urandom_range(1, max_step);
            end
        endcase
        p = packet_of($urandom_range(0, 99) >= 8, s, packet_clock, $urandom,
                      8'($urandom_range(CHANNEL_MIN, CHANNEL_MAX)), TRUST_MAGIC, TRUST_VERSION);
        // Trusted words, single-field near misses and plain noise.
        case ($urandom_range(0, 7))
            0, 1: begin
            end
            2: begin
                p.session = '0;
            end
            3: begin
                p.channel = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(7, 255));
            end
            4: begin
                p.header_magic ^= 32'd1 << $urandom_range(0, 31);
            end
            5: begin
                p.header_version = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(2, 255));
            end
            default: begin
                p.session        = $urandom;
                p.channel        = 8'($urandom);
                p.header_magic   = $urandom;
                p.header_version = 8'($urandom);
            end
        endcase
        return p;
    endfunction

    function automatic void check_flag(string name, logic want, logic got);
        if (got !== want) begin
            $display("%0t: %s expected %0b, got %0b", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_WINDOW_MS: held_window_ms = data;
            REG_THRESHOLD: held_threshold = data[15:0];
            default: begin
            end
        endcase
    endtask

    // Waits until every word has gone in and every verdict has come out.
    task automatic wait_quiet();
        while (packets_waiting.size() > 0 || i_in_valid || verdicts_due.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic run_traffic(int words, int max_step);
        repeat (words) packets_waiting.push_back(random_packet(max_step));
        wait_quiet();
    endtask

    // Input driver: presents queued words, with random gaps between them when idling is on.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                verdicts_due.push_back(rate_verdict(i_in_word));
                if (idling_on && $urandom_range(0, 3) == 0) begin
                    send_hold = $urandom_range(1, 7);
                end
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_hold > 0) begin
                    send_hold--;
                    i_in_valid <= 1'b0;
                end else if (packets_waiting.size() > 0) begin
                    i_in_word  <= packets_waiting.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each accepted verdict and, when idling is on, stalls in bursts.
    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: verdict expected none, got %b", $time, o_out_word);
                    mismatches++;
                end else begin
                    want = verdicts_due.pop_front();
                    check_flag("drop", want.drop, o_out_word.drop);
                    check_flag("new_entry", want.new_entry, o_out_word.new_entry);
                    check_flag("evicted", want.evicted, o_out_word.evicted);
                end
            end
            if (take_hold > 0) begin
                take_hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (idling_on && $urandom_range(0, 7) == 0) begin
                    take_hold = $urandom_range(1, 7);
                end
            end
        end
    end

    // Stimulus sequence.
    initial begin
        t_source src_a;
        t_source src_b;
        t_source src_c;
        t_source src_d;
        int      i;

        // Pool of sources, some sharing an address or a port with a neighbour.
        for (i = 0; i < POOL_SIZE; i++) begin
            case (i % 4)
                0: begin
                    source_pool[i].hi   = '0;
                    source_pool[i].lo   = {32'd0, $urandom};
                    source_pool[i].port = 16'($urandom);
                end
                1: begin
                    source_pool[i]      = source_pool[i - 1];
                    source_pool[i].port = ~source_pool[i - 1].port;
                end
                2: begin
                    source_pool[i]    = source_pool[i - 1];
                    source_pool[i].hi = source_pool[i].hi ^ (64'd1 << $urandom_range(0, 63));
                end
                default: begin
                    source_pool[i].hi   = {$urandom, $urandom};
                    source_pool[i].lo   = {$urandom, $urandom};
                    source_pool[i].port = 16'($urandom);
                end
            endcase
        end
        src_a = '0;
        src_b = '1;
        src_c = '{hi: 64'h0123_4567_89AB_CDEF, lo: 64'h0000_0000_C0A8_0001, port: 16'd443};
        src_d = src_a;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words under the reset settings.
        packets_waiting.push_back(packet_of(1'b0, src_b, '1, '1, 8'hFF, '1, 8'hFF));
        packets_waiting.push_back(packet_of(1'b0, src_a, '0, '0, 8'h00, '0, 8'h00));
        packets_waiting.push_back(packet_of(1'b1, src_a, '0, '0, 8'h00, '0, 8'h00));
        packets_waiting.push_back(packet_of(1'b1, src_b, '1, '1, 8'hFF, '1, 8'hFF));
        // Elapsed time across the wrap of the millisecond clock.
        packets_waiting.push_back(packet_of(1'b1, src_b, 48'd5, '0, 8'h00, '0, 8'h00));
        // Trusted at both ends of the channel range, then one-field misses.
        packets_waiting.push_back(packet_of(1'b1, src_c, 48'd10, 32'd1, CHANNEL_MIN,
                                            TRUST_MAGIC, TRUST_VERSION));
        packets_waiting.push_back(packet_of(1'b1, src_c, 48'd10, '1, CHANNEL_MAX,
                                            TRUST_MAGIC, TRUST_VERSION));
        packets_waiting.push_back(packet_of(1'b1, src_c, 48'd11, 32'd7, 8'd0,
                                            TRUST_MAGIC, TRUST_VERSION));
        packets_waiting.push_back(packet_of(1'b1, src_c, 48'd11, 32'd7, 8'd7,
                                            TRUST_MAGIC, TRUST_VERSION));
        packets_waiting.push_back(packet_of(1'b1, src_c, 48'd12, 32'd7, 8'd3,
                                            TRUST_MAGIC, 8'd0));
        packets_waiting.push_back(packet_of(1'b1, src_c, 48'd12, 32'd7, 8'd3,
                                            TRUST_MAGIC, 8'd2));
        packets_waiting.push_back(packet_of(1'b1, src_c, 48'd13, 32'd0, 8'd3,
                                            TRUST_MAGIC, TRUST_VERSION));
        packets_waiting.push_back(packet_of(1'b1, src_c, 48'd13, 32'd7, 8'd3,
                                            TRUST_MAGIC ^ 32'd1, TRUST_VERSION));
        packets_waiting.push_back(packet_of(1'b1, src_c, 48'd14, 32'd7, 8'd3,
                                            TRUST_MAGIC ^ 32'h8000_0000, TRUST_VERSION));
        // Elapsed equal to the window keeps it; one more millisecond restarts it.
        packets_waiting.push_back(packet_of(1'b1, src_a, 48'd1000, '0, 8'h00, '0, 8'h00));
        packets_waiting.push_back(packet_of(1'b1, src_a, 48'd1001, '0, 8'h00, '0, 8'h00));
        // Keys that differ from an existing one in a single field.
        src_d.port = 16'd1;
        packets_waiting.push_back(packet_of(1'b1, src_d, 48'd1001, '0, 8'h00, '0, 8'h00));
        src_d      = src_a;
        src_d.lo   = 64'd1;
        packets_waiting.push_back(packet_of(1'b1, src_d, 48'd1001, '0, 8'h00, '0, 8'h00));
        src_d      = src_a;
        src_d.hi   = 64'h8000_0000_0000_0000;
        packets_waiting.push_back(packet_of(1'b1, src_d, 48'd1001, '0, 8'h00, '0, 8'h00));
        wait_quiet();

        // Longest window: one source counts past the threshold and then
        // stays dropped.
        write_reg(REG_WINDOW_MS, 32'hFFFF_FFFF);
        write_reg(REG_THRESHOLD, {16'd0, 16'd30});
        repeat (40) begin
            packets_waiting.push_back(packet_of(1'b1, src_a, 48'd2000, '0, 8'h00, '0, 8'h00));
        end
        wait_quiet();

        // Undecoded registers must leave the settings alone.
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);

        idling_on    = 1'b1;
        packet_clock = 48'd5000;
        write_reg(REG_WINDOW_MS, 32'd50);
        write_reg(REG_THRESHOLD, {16'd0, 16'd3});
        run_traffic(PHASE_WORDS, 20);

        write_reg(REG_WINDOW_MS, 32'd0);
        write_reg(REG_THRESHOLD, {16'd0, 16'd0});
        run_traffic(PHASE_WORDS, 3);

        write_reg(REG_WINDOW_MS, $urandom_range(10, 400));
        write_reg(REG_THRESHOLD, {16'd0, 16'($urandom_range(0, 20))});
        run_traffic(PHASE_WORDS, 60);

        // Closing stretch with no idling, starting the clock just below its wrap.
        idling_on    = 1'b0;
        packet_clock = 48'hFFFF_FFFF_F830;
        write_reg(REG_WINDOW_MS, WINDOW_MS_RESET);
        write_reg(REG_THRESHOLD, {16'd0, 16'd5});
        run_traffic(PHASE_WORDS, 12);

        repeat (TABLE_DEPTH + 10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("per_source_rate_limiter_unit_tb: PASS");
        end else begin
            $display("per_source_rate_limiter_unit_tb: FAIL");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #40_000_000;
        $display("per_source_rate_limiter_unit_tb: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
src/psrl_pkg.sv
src/psrl_mem.sv
src/psrl_engine.sv
src/per_source_rate_limiter_unit.sv
bench/per_source_rate_limiter_unit_tb.sv
